// ===== rtl/rbp_pkg.sv =====
// shared types and constants of the rom board pio/dma register block
package rbp_pkg;

	localparam int ROM_WORD_ADDR_BITS_DEF = 16;
	localparam int ROM_SIZE_W = 18;
	localparam int DATA_W = 16;
	localparam int CFG_INDEX_W = 1;

	localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = 18'd131072;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_LOAD  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [3:0] REG_PIO_HI = 4'd0;
	localparam logic [3:0] REG_PIO_LO = 4'd1;
	localparam logic [3:0] REG_DATA   = 4'd2;
	localparam logic [3:0] REG_DMA_HI = 4'd3;
	localparam logic [3:0] REG_DMA_LO = 4'd4;
	localparam logic [3:0] REG_COUNT  = 4'd5;
	localparam logic [3:0] REG_ID_WR  = 4'd6;
	localparam logic [3:0] REG_ID_RD  = 4'd7;
	localparam logic [3:0] REG_MBOARD = 4'd14;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMAP    = 1'd1;

	localparam logic [31:0] REMAP_KEEP_MASK  = 32'h103f_ffff;
	localparam logic [31:0] REMAP_SHIFT_MASK = 32'h07c0_0000;
	localparam logic [DATA_W-1:0] ALL_ONES   = 16'hffff;
	localparam logic [DATA_W-1:0] ONE_VALUE  = 16'h0001;

	typedef struct packed {
		logic              is_rom;
		logic              odd_off;
		logic              w_odd;
		logic [DATA_W-1:0] value;
	} rd_info_t;

endpackage

// ===== rtl/rbp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module rbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rbp_regs.sv =====
// register state, decode and rom address generation of the accepted beat
module rbp_regs #(
	parameter int ROM_WORD_ADDR_BITS = rbp_pkg::ROM_WORD_ADDR_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 acc,
	input  rbp_pkg::func_t                       func,
	input  logic [3:0]                           reg_index,
	input  logic [rbp_pkg::DATA_W-1:0]           wdata,
	input  logic [15:0]                          load_word_addr,
	input  logic                                 cfg_we,
	input  logic [rbp_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rbp_pkg::ROM_SIZE_W-1:0]       cfg_wdata,
	output rbp_pkg::rd_info_t                    info,
	output logic [ROM_WORD_ADDR_BITS-2:0]        even_raddr,
	output logic [ROM_WORD_ADDR_BITS-2:0]        odd_raddr,
	output logic                                 we_even,
	output logic                                 we_odd,
	output logic [ROM_WORD_ADDR_BITS-2:0]        waddr
);

	localparam int AW = ROM_WORD_ADDR_BITS;

	logic [31:0]                      pio_off_q;
	logic                             autoinc_q;
	logic [30:0]                      dma_off_q;
	logic [15:0]                      dma_cnt_q;
	logic [rbp_pkg::ROM_SIZE_W-1:0]   rom_size_q;
	logic                             remap_q;

	logic [31:0] off_rm;
	logic [28:0] off29;
	logic [29:0] end_byte;
	logic        crypto;
	logic        oor;
	logic [AW-1:0] word;
	logic [AW-1:0] laddr;
	logic        data_access;

	always_comb begin
		off_rm = pio_off_q;
		if (remap_q && !pio_off_q[29]) begin
			off_rm = (pio_off_q & rbp_pkg::REMAP_KEEP_MASK)
				| ((pio_off_q & rbp_pkg::REMAP_SHIFT_MASK) << 1);
		end
		off29 = off_rm[28:0];
		end_byte = {1'b0, off29} + 30'd2;
		crypto = remap_q && pio_off_q[30];
		oor = end_byte > {12'd0, rom_size_q};
		word = off29[AW:1];
	end

	// word w+1 lives in the even bank one row up when w is odd
	assign odd_raddr  = word[AW-1:1];
	assign even_raddr = word[AW-1:1] + (AW-1)'(word[0]);

	assign laddr   = AW'(load_word_addr);
	assign waddr   = laddr[AW-1:1];
	assign we_even = acc && (func == rbp_pkg::FUNC_LOAD) && !laddr[0];
	assign we_odd  = acc && (func == rbp_pkg::FUNC_LOAD) && laddr[0];

	assign data_access = acc && (reg_index == rbp_pkg::REG_DATA)
		&& ((func == rbp_pkg::FUNC_READ) || (func == rbp_pkg::FUNC_WRITE));

	always_comb begin
		info = '0;
		info.odd_off = off29[0];
		info.w_odd = word[0];
		if (func == rbp_pkg::FUNC_READ) begin
			unique case (reg_index)
				rbp_pkg::REG_PIO_HI: info.value = {autoinc_q | pio_off_q[31], pio_off_q[30:16]};
				rbp_pkg::REG_PIO_LO: info.value = pio_off_q[15:0];
				rbp_pkg::REG_DATA: begin
					if (crypto) begin
						info.value = '0;
					end else if (oor) begin
						info.value = rbp_pkg::ALL_ONES;
					end else begin
						info.is_rom = 1'b1;
					end
				end
				rbp_pkg::REG_DMA_HI: info.value = {1'b0, dma_off_q[30:16]};
				rbp_pkg::REG_DMA_LO: info.value = dma_off_q[15:0];
				rbp_pkg::REG_COUNT:  info.value = dma_cnt_q;
				rbp_pkg::REG_ID_WR:  info.value = rbp_pkg::ONE_VALUE;
				rbp_pkg::REG_ID_RD:  info.value = '0;
				rbp_pkg::REG_MBOARD: info.value = rbp_pkg::ONE_VALUE;
				default:             info.value = rbp_pkg::ALL_ONES;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pio_off_q <= '0;
			autoinc_q <= 1'b0;
			dma_off_q <= '0;
			dma_cnt_q <= '0;
			rom_size_q <= rbp_pkg::ROM_SIZE_RESET;
			remap_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rbp_pkg::CFG_ROM_SIZE: rom_size_q <= cfg_wdata;
					rbp_pkg::CFG_REMAP:    remap_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (data_access && autoinc_q) begin
				pio_off_q <= pio_off_q + 32'd2;
			end
			if (acc && (func == rbp_pkg::FUNC_WRITE)) begin
				unique case (reg_index)
					rbp_pkg::REG_PIO_HI: begin
						autoinc_q <= wdata[15];
						pio_off_q <= {1'b0, wdata[14:0], pio_off_q[15:0]};
					end
					rbp_pkg::REG_PIO_LO: pio_off_q <= {pio_off_q[31:16], wdata};
					rbp_pkg::REG_DMA_HI: dma_off_q <= {wdata[14:0], dma_off_q[15:0]};
					rbp_pkg::REG_DMA_LO: dma_off_q <= {dma_off_q[30:16], wdata};
					rbp_pkg::REG_COUNT:  dma_cnt_q <= wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/rbp_resp.sv =====
// rom read stage, byte assembly and output register
module rbp_resp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  rbp_pkg::rd_info_t          info,
	input  logic [rbp_pkg::DATA_W-1:0] even_rd,
	input  logic [rbp_pkg::DATA_W-1:0] odd_rd,
	output logic                       ready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [rbp_pkg::DATA_W-1:0] m_tdata
);

	logic                       valid_s1;
	rbp_pkg::rd_info_t          info_s1;
	logic                       m_valid_q;
	logic [rbp_pkg::DATA_W-1:0] m_data_q;
	logic                       advance;
	logic [rbp_pkg::DATA_W-1:0] word_a;
	logic [rbp_pkg::DATA_W-1:0] word_b;
	logic [rbp_pkg::DATA_W-1:0] value;

	assign advance = valid_s1 && (!m_valid_q || m_tready);
	assign ready = !valid_s1 || !m_valid_q || m_tready;

	always_comb begin
		word_a = info_s1.w_odd ? odd_rd : even_rd;
		word_b = info_s1.w_odd ? even_rd : odd_rd;
		value = info_s1.value;
		if (info_s1.is_rom) begin
			value = info_s1.odd_off ? {word_b[7:0], word_a[15:8]} : word_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			info_s1 <= info;
		end
		if (advance) begin
			m_data_q <= value;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

// ===== rtl/rom_board_pio_dma_registers.sv =====
// top level of the rom board pio/dma register block
// usage:
//   input beats on s_*: s_tuser carries the function (read, write, load) and
//   the register index, s_tdata the write data and the rom load word address
//   every input beat gives exactly one output beat on m_*, the read value or
//   zero for writes and loads
//   configuration (rom size, 4mb remap) goes through cfg_we/cfg_index/cfg_wdata
//   while no beat is in flight
// throughput: one beat per cycle while m_tready is high; register state updates
//   on the accept edge and the rom sits in two word-interleaved banks (even and
//   odd words), so an unaligned data port read fetches both bytes in one access
// path: an accepted beat passes the bank read stage, then the output register,
//   before it shows on m_tvalid
// reset: pio/dma offsets, count and autoincrement clear, rom size returns to
//   128k bytes, remap off; rom contents are kept and undefined until loaded
// stall: with m_tready low the output register and the read stage fill and
//   s_tready drops; nothing is lost or repeated
module rom_board_pio_dma_registers #(
	parameter int ROM_WORD_ADDR_BITS = rbp_pkg::ROM_WORD_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [31:0]                         s_tdata,   // wdata, load_word_addr
	input  logic [5:0]                          s_tuser,   // func, reg_index
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,   // rdata
	input  logic                                cfg_we,
	input  logic [rbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rbp_pkg::ROM_SIZE_W-1:0]      cfg_wdata
);

	localparam int BANK_DEPTH = 2 ** (ROM_WORD_ADDR_BITS - 1);

	logic                            acc;
	rbp_pkg::rd_info_t               info;
	logic [ROM_WORD_ADDR_BITS-2:0]   even_raddr;
	logic [ROM_WORD_ADDR_BITS-2:0]   odd_raddr;
	logic [ROM_WORD_ADDR_BITS-2:0]   waddr;
	logic                            we_even;
	logic                            we_odd;
	logic [rbp_pkg::DATA_W-1:0]      even_rd;
	logic [rbp_pkg::DATA_W-1:0]      odd_rd;

	assign acc = s_tvalid && s_tready;

	rbp_regs #(
		.ROM_WORD_ADDR_BITS(ROM_WORD_ADDR_BITS)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.func          (rbp_pkg::func_t'(s_tuser[1:0])),
		.reg_index     (s_tuser[5:2]),
		.wdata         (s_tdata[15:0]),
		.load_word_addr(s_tdata[31:16]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.info          (info),
		.even_raddr    (even_raddr),
		.odd_raddr     (odd_raddr),
		.we_even       (we_even),
		.we_odd        (we_odd),
		.waddr         (waddr)
	);

	rbp_ram #(
		.WIDTH(rbp_pkg::DATA_W),
		.DEPTH(BANK_DEPTH)
	) u_ram_even (
		.clk  (clk),
		.we   (we_even),
		.waddr(waddr),
		.wdata(s_tdata[15:0]),
		.re   (acc),
		.raddr(even_raddr),
		.rdata(even_rd)
	);

	rbp_ram #(
		.WIDTH(rbp_pkg::DATA_W),
		.DEPTH(BANK_DEPTH)
	) u_ram_odd (
		.clk  (clk),
		.we   (we_odd),
		.waddr(waddr),
		.wdata(s_tdata[15:0]),
		.re   (acc),
		.raddr(odd_raddr),
		.rdata(odd_rd)
	);

	rbp_resp u_resp (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.info    (info),
		.even_rd (even_rd),
		.odd_rd  (odd_rd),
		.ready   (s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ===== rtl/rbp_checker.sv =====
// port-level checks of the register block and their binding
module rbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [5:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic s_beat;

	assign s_beat = s_tvalid && s_tready;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// accepted beat reaches m_tvalid when the sink keeps taking
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_beat && m_tready) ##1 m_tready |=> m_tvalid)
		else $error("result missing after accepted beat");

	// writes, loads and unused function codes return zero
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s_beat && m_tready && (s_tuser[1:0] != rbp_pkg::FUNC_READ)) ##1 m_tready
		|=> m_tdata == '0)
		else $error("non-read beat returned nonzero data");

	// id write register reads as one
	a_id_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s_beat && m_tready && (s_tuser[1:0] == rbp_pkg::FUNC_READ)
			&& (s_tuser[5:2] == rbp_pkg::REG_ID_WR)) ##1 m_tready
		|=> m_tdata == rbp_pkg::ONE_VALUE)
		else $error("id register read wrong value");

endmodule

bind rom_board_pio_dma_registers rbp_checker u_rbp_checker (.*);

// ===== sim/rbp_checker.sv =====
`timescale 1ns / 1ps
// checker for the rom board register block: tracks offsets and rom contents and compares read data
module tb_rbp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // wdata, load_word_addr
	input  logic [5:0]                      s_tuser,   // func, reg_index
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [15:0]                     m_tdata,   // rdata
	input  logic                            cfg_we,
	input  logic [rbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rbp_pkg::ROM_SIZE_W-1:0]  cfg_wdata,
	output int                              failures,
	output int                              outstanding
);
	import rbp_pkg::*;

	localparam logic [31:0] OFFSET_MASK = 32'h1fff_ffff;
	localparam int SHOWN_MAX = 10;

	logic [ROM_SIZE_W-1:0] rom_size;
	logic                  remap_en;
	logic [31:0]           pio_ofs;
	logic                  pio_autoinc;
	logic [30:0]           dma_ofs;
	logic [15:0]           dma_cnt;
	logic [15:0]           rom_image [0:65535];
	logic [15:0]           rdata_due [$];
	int                    n_fail;
	logic [15:0]           want;

	function automatic logic [7:0] rom_byte(input logic [31:0] addr);
		logic [15:0] w;
		w = rom_image[addr[16:1]];
		return addr[0] ? w[15:8] : w[7:0];
	endfunction

	function automatic logic [15:0] data_port_value();
		logic [31:0] addr;
		logic [32:0] span_end;
		addr = pio_ofs;
		// crypto window
		if (remap_en && addr[30])
			return '0;
		if (remap_en && !addr[29])
			addr = (addr & REMAP_KEEP_MASK) | ((addr & REMAP_SHIFT_MASK) << 1);
		addr = addr & OFFSET_MASK;
		span_end = {1'b0, addr} + 33'd2;
		if (span_end > {15'd0, rom_size})
			return ALL_ONES;
		return {rom_byte(addr + 32'd1), rom_byte(addr)};
	endfunction

	function automatic logic [15:0] rdata_of_access(input func_t f, input logic [3:0] idx,
			input logic [15:0] wd, input logic [15:0] la);
		logic [15:0] r;
		r = '0;
		case (f)
		FUNC_READ: begin
			case (idx)
			REG_PIO_HI: r = pio_ofs[31:16] | {pio_autoinc, 15'd0};
			REG_PIO_LO: r = pio_ofs[15:0];
			REG_DATA: begin
				r = data_port_value();
				if (pio_autoinc)
					pio_ofs = pio_ofs + 32'd2;
			end
			REG_DMA_HI: r = {1'b0, dma_ofs[30:16]};
			REG_DMA_LO: r = dma_ofs[15:0];
			REG_COUNT: r = dma_cnt;
			REG_ID_WR, REG_MBOARD: r = ONE_VALUE;
			REG_ID_RD: r = '0;
			default: r = ALL_ONES;
			endcase
		end
		FUNC_WRITE: begin
			case (idx)
			REG_PIO_HI: begin
				pio_autoinc = wd[15];
				pio_ofs[31:16] = {1'b0, wd[14:0]};
			end
			REG_PIO_LO: pio_ofs[15:0] = wd;
			REG_DATA: begin
				if (pio_autoinc)
					pio_ofs = pio_ofs + 32'd2;
			end
			REG_DMA_HI: dma_ofs[30:16] = wd[14:0];
			REG_DMA_LO: dma_ofs[15:0] = wd;
			REG_COUNT: dma_cnt = wd;
			default: ;
			endcase
		end
		FUNC_LOAD: rom_image[la] = wd;
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_size = ROM_SIZE_RESET;
			remap_en = 1'b0;
			pio_ofs = '0;
			pio_autoinc = 1'b0;
			dma_ofs = '0;
			dma_cnt = '0;
			rdata_due.delete();
			n_fail = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROM_SIZE)
					rom_size = cfg_wdata;
				else if (cfg_index == CFG_REMAP)
					remap_en = cfg_wdata[0];
			end
			if (s_tvalid && s_tready)
				rdata_due = {rdata_due, rdata_of_access(func_t'(s_tuser[1:0]), s_tuser[5:2],
					s_tdata[15:0], s_tdata[31:16])};
			if (m_tvalid && m_tready) begin
				if (rdata_due.size() == 0) begin
					if (n_fail < SHOWN_MAX)
						$display("%0t: result beat %h with no access pending", $realtime, m_tdata);
					n_fail++;
				end else begin
					want = rdata_due.pop_front();
					if (m_tdata !== want) begin
						if (n_fail < SHOWN_MAX)
							$display("%0t: rdata expected %h, got %h", $realtime, want, m_tdata);
						n_fail++;
					end
				end
			end
			failures <= n_fail;
			outstanding <= rdata_due.size();
		end
	end

endmodule

// ===== sim/tb_rom_board_pio_dma_registers.sv =====
`timescale 1ns / 1ps
// testbench top for the rom board register block: clock, reset, stimulus and verdict
module tb_rom_board_pio_dma_registers;
	import rbp_pkg::*;

	localparam int ROM_WORDS = 128;
	localparam int HOLD_CYCLES = 200;
	localparam logic [3:0] REG_OTHER = 4'd15;
	localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_MAX = 18'd131072;
	localparam logic [ROM_SIZE_W-1:0] ROM_BYTES = 18'd256;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [31:0]            s_tdata;   // wdata, load_word_addr
	logic [5:0]             s_tuser;   // func, reg_index
	logic                   m_tvalid;
	logic                   m_tready;
	logic [15:0]            m_tdata;   // rdata
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [ROM_SIZE_W-1:0]  cfg_wdata;
	int                     failures;
	int                     outstanding;
	int                     send_idle_pct;
	int                     stall_pct;
	logic                   hold_req;
	int                     hold_left;
	int                     beats_sent;
	logic [ROM_SIZE_W-1:0]  cur_rom_size;

	rom_board_pio_dma_registers uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	tb_rbp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.failures(failures), .outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random stalls, or a long hold when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req && hold_left == 0) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 1) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			hold_left <= 0;
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", outstanding);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [15:0] rnd16(input int unsigned top_val);
		return 16'($urandom_range(top_val));
	endfunction

	function automatic logic [3:0] rnd4(input int unsigned top_val);
		return 4'($urandom_range(top_val));
	endfunction

	task automatic send_beat(input func_t f, input logic [3:0] idx, input logic [15:0] wd,
			input logic [15:0] la);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {idx, f};
		s_tdata <= {la, wd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [ROM_SIZE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_ROM_SIZE)
			cur_rom_size = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_sequence();
		logic [15:0] hi;
		logic [15:0] lo;
		logic [31:0] bound;
		logic [3:0]  idx;
		int unsigned back;
		int          kind;
		kind = $urandom_range(99);
		if (kind < 45) begin
			// set up the pio offset, then a run of data port beats and sometimes a pio offset read
			case ($urandom_range(3))
			0: hi = rnd16(1);
			1: hi = rnd16(65535);
			2: hi = 16'd1 << $urandom_range(14);
			default: hi = '0;
			endcase
			lo = rnd16(65535);
			if ($urandom_range(3) == 0) begin
				back = $urandom_range(5);
				bound = {14'd0, cur_rom_size} - back;
				hi[14:0] = bound[30:16];
				lo = bound[15:0];
			end
			hi[15] = ($urandom_range(3) != 0);
			send_beat(FUNC_WRITE, REG_PIO_HI, hi, rnd16(65535));
			send_beat(FUNC_WRITE, REG_PIO_LO, lo, rnd16(65535));
			repeat ($urandom_range(8, 1)) begin
				if ($urandom_range(4) == 0)
					send_beat(FUNC_WRITE, REG_DATA, rnd16(65535), rnd16(65535));
				else
					send_beat(FUNC_READ, REG_DATA, rnd16(65535), rnd16(65535));
			end
			if ($urandom_range(1) == 0)
				send_beat(FUNC_READ, rnd4(1), rnd16(65535), rnd16(65535));
		end else if (kind < 60) begin
			case ($urandom_range(2))
			0: idx = REG_DMA_HI;
			1: idx = REG_DMA_LO;
			default: idx = REG_COUNT;
			endcase
			send_beat(FUNC_WRITE, idx, rnd16(65535), rnd16(65535));
			send_beat(FUNC_READ, idx, rnd16(65535), rnd16(65535));
		end else if (kind < 70) begin
			send_beat(FUNC_LOAD, rnd4(15), rnd16(65535), rnd16(65535));
		end else if (kind < 85) begin
			send_beat(FUNC_READ, rnd4(15), rnd16(65535), rnd16(65535));
		end else if (kind < 95) begin
			send_beat(FUNC_WRITE, rnd4(15), rnd16(65535), rnd16(65535));
		end else begin
			send_beat(FUNC_NONE, rnd4(15), rnd16(65535), rnd16(65535));
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input logic [ROM_SIZE_W-1:0] size,
			input logic remap, input int count, input logic pressure);
		int   start;
		logic paused;
		start = beats_sent;
		paused = 1'b0;
		write_cfg(CFG_ROM_SIZE, size);
		write_cfg(CFG_REMAP, {{(ROM_SIZE_W-1){1'b0}}, remap});
		send_idle_pct = idle;
		stall_pct = stall;
		if (pressure) begin
			hold_req <= 1'b1;
			@(posedge clk);
			hold_req <= 1'b0;
		end
		while (beats_sent - start < count) begin
			random_sequence();
			if (pressure && !paused && beats_sent - start >= count / 2) begin
				// let every pending result come back before going on
				s_tvalid <= 1'b0;
				drain();
				paused = 1'b1;
			end
		end
		s_tvalid <= 1'b0;
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		hold_req <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		beats_sent = 0;
		cur_rom_size = ROM_SIZE_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg(CFG_ROM_SIZE, ROM_SIZE_MAX);
		write_cfg(CFG_REMAP, '0);
		// load the low rom words; later rom sizes stay inside them
		for (int w = 0; w < ROM_WORDS; w++)
			send_beat(FUNC_LOAD, rnd4(15), rnd16(65535), w[15:0]);

		send_beat(FUNC_LOAD, REG_DATA, 16'h0000, 16'hffff);
		send_beat(FUNC_LOAD, REG_DATA, 16'hffff, 16'h0001);
		send_beat(FUNC_WRITE, REG_PIO_HI, 16'h8000, 16'h0000);
		send_beat(FUNC_WRITE, REG_PIO_LO, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_DATA, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_DATA, 16'h0000, 16'h0000);
		// odd offset straddles two words
		send_beat(FUNC_WRITE, REG_PIO_LO, 16'h0001, 16'h0000);
		send_beat(FUNC_READ, REG_DATA, 16'h0000, 16'h0000);
		send_beat(FUNC_WRITE, REG_DATA, 16'hffff, 16'hffff);
		send_beat(FUNC_READ, REG_PIO_LO, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_PIO_HI, 16'h0000, 16'h0000);
		// last word inside the rom, then the first one past it
		send_beat(FUNC_WRITE, REG_PIO_LO, 16'hfffe, 16'h0000);
		send_beat(FUNC_WRITE, REG_PIO_HI, 16'h8001, 16'h0000);
		send_beat(FUNC_READ, REG_DATA, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_DATA, 16'h0000, 16'h0000);
		// highest writable even offset, increment carries into bit 31
		send_beat(FUNC_WRITE, REG_PIO_HI, 16'hffff, 16'h0000);
		send_beat(FUNC_WRITE, REG_PIO_LO, 16'hfffe, 16'h0000);
		send_beat(FUNC_READ, REG_DATA, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_PIO_HI, 16'h0000, 16'h0000);
		send_beat(FUNC_WRITE, REG_DMA_HI, 16'hffff, 16'h0000);
		send_beat(FUNC_WRITE, REG_DMA_LO, 16'hffff, 16'h0000);
		send_beat(FUNC_WRITE, REG_COUNT, 16'hffff, 16'h0000);
		send_beat(FUNC_READ, REG_DMA_HI, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_COUNT, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_MBOARD, 16'h0000, 16'h0000);
		send_beat(FUNC_READ, REG_OTHER, 16'h0000, 16'h0000);
		send_beat(FUNC_NONE, REG_DATA, 16'hffff, 16'hffff);
		s_tvalid <= 1'b0;
		drain();

		run_phase(0, 0, ROM_BYTES, 1'b0, 280, 1'b0);
		run_phase(81, 0, ROM_SIZE_W'($urandom_range(ROM_BYTES, 2)), 1'b1, 260, 1'b0);
		run_phase(0, 81, '0, 1'b0, 150, 1'b0);
		run_phase(12, 12, ROM_SIZE_W'($urandom_range(64, 1)), 1'b1, 260, 1'b0);
		run_phase(0, 0, ROM_BYTES, 1'b1, 260, 1'b1);
		run_phase(12, 12, 18'd2, 1'b0, 150, 1'b0);

		$display("%0d beats sent, a rom load first, then every function and register index",
			beats_sent);
		$display("rom size from 0 to %0d bytes, remap on and off, idle and stall phases, long hold",
			ROM_SIZE_MAX);
		if (outstanding != 0)
			$display("%0d read results never arrived", outstanding);
		if (failures == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rbp_pkg.sv
rtl/rbp_ram.sv
rtl/rbp_regs.sv
rtl/rbp_resp.sv
rtl/rom_board_pio_dma_registers.sv
rtl/rbp_checker.sv
sim/rbp_checker.sv
sim/tb_rom_board_pio_dma_registers.sv
